// ===== design/b64d_pkg.sv =====
// shared types, constants and the character classifier for the base64 decoder
`default_nettype none
package b64d_pkg;

   localparam int COUNT_BITS = 24;
   localparam int OC_BITS = COUNT_BITS + 1;
   localparam int MAX_W = 24;
   localparam int TR_W = COUNT_BITS + 2;
   localparam int CMP_W = ((COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W) + 2;
   localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(6291456);
   localparam logic [COUNT_BITS-1:0] GC_MAX = {COUNT_BITS{1'b1}};
   localparam logic [OC_BITS-1:0] OC_MAX = {OC_BITS{1'b1}};
   localparam logic [7:0] PAD_CHAR = 8'h3d;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW = $clog2(Q_DEPTH);
   localparam int Q_CW = $clog2(Q_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SIZE  = 3'd1,
      ST_PAD   = 3'd2,
      ST_CHAR  = 3'd3,
      ST_LARGE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FE_NONE = 2'd0,
      FE_PAD  = 2'd1,
      FE_CHAR = 2'd2
   } first_err_type;

   typedef struct packed {
      logic        valid;
      logic [5:0]  value;
   } sextet_type;

   // one queued job: one to three results for the back end
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  count;
      logic        has_bytes;
      logic        last;
      status_type  status;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c inside {[8'h41:8'h5a]}) begin
         s.value = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7a]}) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         s.value = 6'd62;
      end else if (c == 8'h2f) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== design/b64d_front.sv =====
// front end: takes characters, tracks groups, counters and errors, queues jobs
`default_nettype none
module b64d_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  wire  [7:0]                   text_char,
   input  wire                          final_char,
   input  wire  [b64d_pkg::MAX_W-1:0]   max_bytes,
   output logic                         push,
   output b64d_pkg::job_type            job
);

   logic [17:0]                       store_ff, store_in;
   logic [1:0]                        pos_ff, pos_in;
   logic                              third_pad_ff, third_pad_in;
   logic                              group_bad_ff, group_bad_in;
   logic [b64d_pkg::COUNT_BITS-1:0]   gc_ff, gc_in;
   logic [b64d_pkg::TR_W-1:0]         tr_ff, tr_in;
   logic [b64d_pkg::OC_BITS-1:0]      oc_ff, oc_in;
   b64d_pkg::first_err_type           fe_ff, fe_in;

   b64d_pkg::sextet_type              sx;
   logic                              is_pad;
   logic                              pad_err, char_err, group_ok;
   b64d_pkg::first_err_type           fe_new;
   logic [b64d_pkg::COUNT_BITS-1:0]   gc_new;
   logic [b64d_pkg::TR_W-1:0]         tr_new;
   logic [b64d_pkg::OC_BITS:0]        oc_sum;
   logic [b64d_pkg::OC_BITS-1:0]      oc_new;
   logic [1:0]                        nbytes;
   logic [23:0]                       word;
   logic                              size_bad, too_large;
   b64d_pkg::status_type              fin_status;
   logic                              clear;

   always_comb begin
      sx = b64d_pkg::sextet_of(text_char);
      is_pad = (text_char == b64d_pkg::PAD_CHAR);

      pad_err = (!final_char && (third_pad_ff || is_pad)) || (third_pad_ff && !is_pad);
      char_err = group_bad_ff || (!is_pad && !sx.valid);
      group_ok = (fe_ff == b64d_pkg::FE_NONE) && !pad_err && !char_err;
      fe_new = fe_ff;
      if (fe_ff == b64d_pkg::FE_NONE) begin
         if (pad_err) begin
            fe_new = b64d_pkg::FE_PAD;
         end else if (char_err) begin
            fe_new = b64d_pkg::FE_CHAR;
         end
      end

      // 3 * group count is tracked alongside the count itself
      if (gc_ff == b64d_pkg::GC_MAX) begin
         gc_new = gc_ff;
         tr_new = tr_ff;
      end else begin
         gc_new = gc_ff + 1'b1;
         tr_new = tr_ff + b64d_pkg::TR_W'(3);
      end

      nbytes = third_pad_ff ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
      word = {store_ff, (is_pad ? 6'd0 : sx.value)};
      if (third_pad_ff) begin
         word = word & 24'hfff000;
      end

      oc_sum = {1'b0, oc_ff} + (b64d_pkg::OC_BITS + 1)'(nbytes);
      if (!group_ok) begin
         oc_new = oc_ff;
      end else if (oc_sum[b64d_pkg::OC_BITS]) begin
         oc_new = b64d_pkg::OC_MAX;
      end else begin
         oc_new = oc_sum[b64d_pkg::OC_BITS-1:0];
      end

      size_bad = (gc_new == b64d_pkg::GC_MAX) ||
                 (b64d_pkg::CMP_W'(tr_new) >
                  b64d_pkg::CMP_W'(max_bytes) + b64d_pkg::CMP_W'(2));
      too_large = (oc_new == b64d_pkg::OC_MAX) ||
                  (b64d_pkg::CMP_W'(oc_new) > b64d_pkg::CMP_W'(max_bytes));
      if (size_bad) begin
         fin_status = b64d_pkg::ST_SIZE;
      end else if (fe_new == b64d_pkg::FE_PAD) begin
         fin_status = b64d_pkg::ST_PAD;
      end else if (fe_new == b64d_pkg::FE_CHAR) begin
         fin_status = b64d_pkg::ST_CHAR;
      end else if (too_large) begin
         fin_status = b64d_pkg::ST_LARGE;
      end else begin
         fin_status = b64d_pkg::ST_OK;
      end

      store_in = store_ff;
      pos_in = pos_ff;
      third_pad_in = third_pad_ff;
      group_bad_in = group_bad_ff;
      gc_in = gc_ff;
      tr_in = tr_ff;
      oc_in = oc_ff;
      fe_in = fe_ff;
      clear = 1'b0;
      push = 1'b0;
      job.word = word;
      job.count = 2'd1;
      job.has_bytes = 1'b0;
      job.last = 1'b1;
      job.status = b64d_pkg::ST_SIZE;

      if (accept) begin
         if (pos_ff != 2'd3) begin
            if (pos_ff == 2'd2) begin
               third_pad_in = is_pad;
               if (!is_pad && !sx.valid) begin
                  group_bad_in = 1'b1;
               end
            end else if (!sx.valid) begin
               group_bad_in = 1'b1;
            end
            store_in = {store_ff[11:0], sx.value};
            pos_in = pos_ff + 1'b1;
            if (final_char) begin
               push = 1'b1;
               clear = 1'b1;
            end
         end else begin
            store_in = '0;
            pos_in = 2'd0;
            third_pad_in = 1'b0;
            group_bad_in = 1'b0;
            gc_in = gc_new;
            tr_in = tr_new;
            oc_in = oc_new;
            fe_in = fe_new;
            if (final_char) begin
               clear = 1'b1;
            end
            if (final_char && fin_status != b64d_pkg::ST_OK) begin
               push = 1'b1;
               job.status = fin_status;
            end else if (group_ok) begin
               push = 1'b1;
               job.count = nbytes;
               job.has_bytes = 1'b1;
               job.last = final_char;
               job.status = b64d_pkg::ST_OK;
            end
         end
      end

      if (clear) begin
         store_in = '0;
         pos_in = 2'd0;
         third_pad_in = 1'b0;
         group_bad_in = 1'b0;
         gc_in = '0;
         tr_in = '0;
         oc_in = '0;
         fe_in = b64d_pkg::FE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         pos_ff <= 2'd0;
         third_pad_ff <= 1'b0;
         group_bad_ff <= 1'b0;
         gc_ff <= '0;
         tr_ff <= '0;
         oc_ff <= '0;
         fe_ff <= b64d_pkg::FE_NONE;
      end else begin
         store_ff <= store_in;
         pos_ff <= pos_in;
         third_pad_ff <= third_pad_in;
         group_bad_ff <= group_bad_in;
         gc_ff <= gc_in;
         tr_ff <= tr_in;
         oc_ff <= oc_in;
         fe_ff <= fe_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/b64d_queue.sv =====
// small job queue between the front and back ends
`default_nettype none
module b64d_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  var b64d_pkg::job_type push_job,
   input  wire                  pop,
   output b64d_pkg::job_type    head_job,
   output logic                 empty,
   output logic                 full
);

   b64d_pkg::job_type              entry_ff [b64d_pkg::Q_DEPTH];
   logic [b64d_pkg::Q_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::Q_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::Q_CW-1:0]      count_ff, count_in;

   always_comb begin
      empty = (count_ff == '0);
      full = (count_ff == b64d_pkg::Q_CW'(b64d_pkg::Q_DEPTH));
      head_job = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/b64d_back.sv =====
// back end: splits each job into result items behind an output register
`default_nettype none
module b64d_back (
   input  wire                  clock,
   input  wire                  reset,
   input  var b64d_pkg::job_type head_job,
   input  wire                  q_empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [3:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   logic                   vld_ff, vld_in;
   logic [1:0]             idx_ff, idx_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   bvalid_ff, bvalid_in;
   logic                   end_ff, end_in;
   b64d_pkg::status_type   status_ff, status_in;
   logic                   load, job_done;
   logic [7:0]             sel_byte;

   always_comb begin
      case (idx_ff)
         2'd0: sel_byte = head_job.word[23:16];
         2'd1: sel_byte = head_job.word[15:8];
         2'd2: sel_byte = head_job.word[7:0];
         default: sel_byte = 8'd0;
      endcase

      load = !q_empty && (!vld_ff || rsp_tready);
      job_done = (idx_ff + 2'd1 == head_job.count);
      pop = load && job_done;

      vld_in = vld_ff && !rsp_tready;
      idx_in = idx_ff;
      byte_in = byte_ff;
      bvalid_in = bvalid_ff;
      end_in = end_ff;
      status_in = status_ff;
      if (load) begin
         vld_in = 1'b1;
         idx_in = job_done ? 2'd0 : idx_ff + 2'd1;
         byte_in = head_job.has_bytes ? sel_byte : 8'd0;
         bvalid_in = head_job.has_bytes;
         end_in = head_job.last && job_done;
         status_in = job_done ? head_job.status : b64d_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bvalid_ff <= bvalid_in;
      end_ff <= end_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = byte_ff;
   assign rsp_tuser = {status_ff, bvalid_ff};
   assign rsp_tlast = end_ff;

endmodule
`default_nettype wire

// ===== design/base64_strict_decoder.sv =====
// top level of the strict base64 decoder
//
//   port group   dir   content
//   req_*        in    tdata = text_char, tlast = final_char
//   rsp_*        out   tdata = data_byte, tuser = byte_valid, status; tlast = stream_end
//   csr_*        in    max_output_bytes write
//
// one character is taken per cycle while req_tready is high; a completed group yields
// up to three result items, one per cycle while rsp_tready is high, so the result side
// keeps pace with the character side; a character's first result passes the job queue,
// then the output register. req_tready drops only when the four-entry job queue is full.
// reset is synchronous; it clears the stream state and loads the byte limit default.
`default_nettype none
module base64_strict_decoder (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [7:0]                   req_tdata,   // [7:0] text_char
   input  wire                          req_tlast,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] data_byte
   output logic [3:0]                   rsp_tuser,   // [0] byte_valid, [3:1] status
   output logic                         rsp_tlast,
   input  wire                          csr_wr_en,
   input  wire  [b64d_pkg::MAX_W-1:0]   csr_wr_data
);

   logic [b64d_pkg::MAX_W-1:0]   max_bytes_ff, max_bytes_in;
   logic                         accept;
   logic                         q_push, q_pop, q_empty, q_full;
   b64d_pkg::job_type            push_job, head_job;

   assign max_bytes_in = csr_wr_en ? csr_wr_data : max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= b64d_pkg::MAX_RESET;
      end else begin
         max_bytes_ff <= max_bytes_in;
      end
   end

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_char  (req_tdata),
      .final_char (req_tlast),
      .max_bytes  (max_bytes_ff),
      .push       (q_push),
      .job        (push_job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_empty    (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!q_full || q_pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job queue underflow");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3:1] != b64d_pkg::ST_OK) |-> (rsp_tlast && !rsp_tuser[0]))
      else $error("error status on a result that is not a bare stream end");

   a_input_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |-> q_push)
      else $error("final character produced no job");

endmodule
`default_nettype wire
